FILE: rtl/ppdac_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the ping-pong PWM/DAC audio output.
// No dependencies; imported by every module of the block.
package ppdac_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_DAC_OFFSET      = 3'd0,
    REG_DAC_GAIN        = 3'd1,
    REG_DAC_FRAC_BITS   = 3'd2,
    REG_PWM_PERIOD      = 3'd3,
    REG_DAC_TAKES_FIRST = 3'd4
  } reg_idx_e;

  localparam int SAMPLE_W = 16;
  localparam int SIDX_W   = 10;
  localparam int SCNT_W   = 11;
  localparam int DAC_W    = 10;

  typedef struct packed {
    logic signed [31:0] dac_offset;
    logic signed [16:0] dac_gain;
    logic [4:0]         dac_frac_bits;
    logic [15:0]        pwm_period;
    logic               dac_takes_first;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic bsel;
    logic [SIDX_W-1:0]   index;
    logic [SAMPLE_W-1:0] data;
  } sample_wr_t;

  typedef struct packed {
    logic en;
    logic bsel;
  } sample_rd_t;

  typedef struct packed {
    logic underflow;
    logic playing_buffer;
    logic buffer_swapped;
    logic second_ok;
  } tick_meta_t;

  typedef struct packed {
    logic              underflow;
    logic [15:0]       pwm_first;
    logic [15:0]       pwm_second;
    logic [DAC_W-1:0]  dac_code;
    logic              playing_buffer;
    logic              buffer_swapped;
  } result_t;

endpackage

FILE: rtl/ping_pong_audio_pwm_dac_output.sv
`timescale 1ns / 1ps
// Top level of the ping-pong PWM/DAC audio output: ports, config registers, packing.
// Depends on ppdac_pkg, ppdac_ctrl, ppdac_store and ppdac_math.
//
//   channel  direction  ports                      carries
//   in_      sink       tvalid tready tdata tuser  sample write, count set, tick
//   out_     source     tvalid tready tdata tuser  one result per tick
//   cfg      APB slave  psel penable pwrite ...    five scaling registers
//
// One item is taken per cycle while in_tready is high. A tick reads its sample pair
// from the even/odd bank memory in the accept cycle; its result passes three registered
// stages (memory read, multiply, scale and clamp). Writes and count sets give no result.
// Reset clears counts, playing buffer, read index and the pipeline; sample memory
// is not cleared. A stalled output holds the pipeline and input ready drops only
// once all three stages are full.
module ping_pong_audio_pwm_dac_output #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // sample_index[9:0], sample_value[25:10], sample_count[36:26]
  input  logic [2:0]  in_tuser,  // req_type[1:0], buffer_sel[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // pwm_first[15:0], pwm_second[31:16], dac_code[41:32],
                                 // playing_buffer[42]
  output logic [1:0]  out_tuser, // underflow[0], buffer_swapped[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppdac_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH + 2);

  cfg_t       cfg_r;
  sample_wr_t wr;
  sample_rd_t rd;
  tick_meta_t meta;
  result_t    result;
  logic [IW-1:0]       rd_index;
  logic [SAMPLE_W-1:0] first_q;
  logic [SAMPLE_W-1:0] second_q;
  logic                tick_load;
  logic                in_fire;
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dac_offset      <= 32'sd0;
      cfg_r.dac_gain        <= 17'sd1;
      cfg_r.dac_frac_bits   <= 5'd16;
      cfg_r.pwm_period      <= 16'd1000;
      cfg_r.dac_takes_first <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DAC_OFFSET:      cfg_r.dac_offset      <= pwdata;
        REG_DAC_GAIN:        cfg_r.dac_gain        <= pwdata[16:0];
        REG_DAC_FRAC_BITS:   cfg_r.dac_frac_bits   <= pwdata[4:0];
        REG_PWM_PERIOD:      cfg_r.pwm_period      <= pwdata[15:0];
        REG_DAC_TAKES_FIRST: cfg_r.dac_takes_first <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DAC_OFFSET:      prdata = cfg_r.dac_offset;
      REG_DAC_GAIN:        prdata = {{15{cfg_r.dac_gain[16]}}, cfg_r.dac_gain};
      REG_DAC_FRAC_BITS:   prdata = {27'd0, cfg_r.dac_frac_bits};
      REG_PWM_PERIOD:      prdata = {16'd0, cfg_r.pwm_period};
      REG_DAC_TAKES_FIRST: prdata = {31'd0, cfg_r.dac_takes_first};
      default:             prdata = '0;
    endcase
  end

  ppdac_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .IW          (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .req         (req_e'(in_tuser[1:0])),
    .buffer_sel  (in_tuser[2]),
    .sample_index(in_tdata[9:0]),
    .sample_value(in_tdata[25:10]),
    .sample_count(in_tdata[36:26]),
    .wr          (wr),
    .rd          (rd),
    .rd_index    (rd_index),
    .tick_load   (tick_load),
    .meta        (meta)
  );

  ppdac_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .IW          (IW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_index(rd_index),
    .first_q (first_q),
    .second_q(second_q)
  );

  ppdac_math u_math (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .tick_load(tick_load),
    .meta     (meta),
    .first_q  (first_q),
    .second_q (second_q),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .result   (result)
  );

  assign out_tdata = {5'd0, result.playing_buffer, result.dac_code,
                      result.pwm_second, result.pwm_first};
  assign out_tuser = {result.buffer_swapped, result.underflow};

endmodule

FILE: rtl/ppdac_store.sv
`timescale 1ns / 1ps
// Sample memory: even and odd banks so one tick reads a sample pair per cycle.
// Depends on ppdac_pkg.
module ppdac_store #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int IW = 11
) (
  input  logic                          clk,
  input  ppdac_pkg::sample_wr_t         wr,
  input  ppdac_pkg::sample_rd_t         rd,
  input  logic [IW-1:0]                 rd_index,
  output logic [ppdac_pkg::SAMPLE_W-1:0] first_q,
  output logic [ppdac_pkg::SAMPLE_W-1:0] second_q
);
  import ppdac_pkg::*;

  localparam int HALF    = (BUFFER_DEPTH + 1) / 2;
  localparam int ENTRIES = 2 * HALF;
  localparam int AW      = $clog2(ENTRIES);
  localparam int RW      = (HALF > 1) ? $clog2(HALF) : 1;

  logic [SAMPLE_W-1:0] even_mem [ENTRIES];
  logic [SAMPLE_W-1:0] odd_mem  [ENTRIES];

  logic [RW-1:0] wr_row;
  logic [RW-1:0] rd_row;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_row  = RW'(wr.index >> 1);
  assign rd_row  = RW'(rd_index >> 1);
  assign wr_addr = wr.bsel ? AW'(HALF) + AW'(wr_row) : AW'(wr_row);
  assign rd_addr = rd.bsel ? AW'(HALF) + AW'(rd_row) : AW'(rd_row);

  always_ff @(posedge clk) begin
    if (wr.en && !wr.index[0]) begin
      even_mem[wr_addr] <= wr.data;
    end
    if (rd.en) begin
      first_q <= even_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.index[0]) begin
      odd_mem[wr_addr] <= wr.data;
    end
    if (rd.en) begin
      second_q <= odd_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/ppdac_ctrl.sv
`timescale 1ns / 1ps
// Request decode and playback state: buffer counts, playing buffer, read index.
// Depends on ppdac_pkg.
module ppdac_ctrl #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int IW = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  ppdac_pkg::req_e               req,
  input  logic                          buffer_sel,
  input  logic [ppdac_pkg::SIDX_W-1:0]  sample_index,
  input  logic [ppdac_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [ppdac_pkg::SCNT_W-1:0]  sample_count,
  output ppdac_pkg::sample_wr_t         wr,
  output ppdac_pkg::sample_rd_t         rd,
  output logic [IW-1:0]                 rd_index,
  output logic                          tick_load,
  output ppdac_pkg::tick_meta_t         meta
);
  import ppdac_pkg::*;

  logic [IW-1:0] counts_r   [2];
  logic [IW-1:0] counts_nxt [2];
  logic          cur_r, cur_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic [IW-1:0] cur_cnt;
  logic [IW-1:0] idx_adv;
  logic [IW-1:0] cnt_sat;
  logic          empty;
  logic          finish;
  logic          tick_go;

  assign cur_cnt = counts_r[cur_r];
  assign idx_adv = idx_r + IW'(2);
  assign empty   = (cur_cnt == '0);
  assign finish  = (cur_cnt <= idx_adv);
  assign tick_go = in_fire && (req == REQ_TICK);
  assign cnt_sat = (32'(sample_count) > 32'(BUFFER_DEPTH)) ? IW'(BUFFER_DEPTH)
                                                          : IW'(sample_count);

  always_comb begin
    counts_nxt[0] = counts_r[0];
    counts_nxt[1] = counts_r[1];
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (in_fire) begin
      unique case (req)
        REQ_WRITE: begin
        end
        REQ_COUNT: begin
          counts_nxt[buffer_sel] = cnt_sat;
        end
        REQ_TICK: begin
          if (!empty) begin
            idx_nxt = idx_adv;
            if (finish) begin
              counts_nxt[cur_r] = '0;
              cur_nxt           = ~cur_r;
              idx_nxt           = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r[0] <= '0;
      counts_r[1] <= '0;
      cur_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      counts_r[0] <= counts_nxt[0];
      counts_r[1] <= counts_nxt[1];
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_comb begin
    wr.en    = in_fire && (req == REQ_WRITE) && (32'(sample_index) < 32'(BUFFER_DEPTH));
    wr.bsel  = buffer_sel;
    wr.index = sample_index;
    wr.data  = sample_value;
    rd.en    = tick_go && !empty;
    rd.bsel  = cur_r;
    rd_index = idx_r;
    tick_load = tick_go;
    meta.underflow      = empty;
    meta.buffer_swapped = !empty && finish;
    meta.playing_buffer = (!empty && finish) ? ~cur_r : cur_r;
    meta.second_ok      = (32'(idx_r) + 32'd1) < 32'(BUFFER_DEPTH);
  end

endmodule

FILE: rtl/ppdac_math.sv
`timescale 1ns / 1ps
// Result pipeline: sample pair capture, PWM and DAC products, DAC scale and clamp.
// Depends on ppdac_pkg; sample data comes from the ppdac_store read registers.
module ppdac_math (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppdac_pkg::cfg_t                cfg,
  input  logic                           tick_load,
  input  ppdac_pkg::tick_meta_t          meta,
  input  logic [ppdac_pkg::SAMPLE_W-1:0] first_q,
  input  logic [ppdac_pkg::SAMPLE_W-1:0] second_q,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppdac_pkg::result_t             result
);
  import ppdac_pkg::*;

  logic       s1_v_r;
  tick_meta_t s1_meta_r;
  logic       s2_v_r;
  tick_meta_t s2_meta_r;
  logic [15:0]        s2_pwm_first_r;
  logic [15:0]        s2_pwm_second_r;
  logic signed [32:0] s2_dac_prod_r;
  logic       out_v_r;
  result_t    out_r;

  logic out_free, s2_free, s1_free;

  logic [SAMPLE_W-1:0] second_s;
  logic [SAMPLE_W-1:0] dac_s;
  logic [31:0]         pwm_first_p;
  logic [31:0]         pwm_second_p;
  logic signed [32:0]  gain_ext;
  logic signed [32:0]  dac_s_ext;
  logic signed [32:0]  dac_prod;
  logic signed [33:0]  dac_sum;
  logic signed [33:0]  dac_shift;
  logic [DAC_W-1:0]    dac_clamp;

  assign out_free = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;

  assign second_s     = s1_meta_r.second_ok ? second_q : '0;
  assign dac_s        = cfg.dac_takes_first ? first_q : second_s;
  assign pwm_first_p  = {~first_q[15], first_q[14:0]} * cfg.pwm_period;
  assign pwm_second_p = {~second_s[15], second_s[14:0]} * cfg.pwm_period;
  assign gain_ext     = {{16{cfg.dac_gain[16]}}, cfg.dac_gain};
  assign dac_s_ext    = {{17{dac_s[15]}}, dac_s};
  assign dac_prod     = gain_ext * dac_s_ext;

  assign dac_sum   = {{2{cfg.dac_offset[31]}}, cfg.dac_offset}
                   + {s2_dac_prod_r[32], s2_dac_prod_r};
  assign dac_shift = dac_sum >>> cfg.dac_frac_bits;

  always_comb begin
    if (dac_shift[33]) begin
      dac_clamp = '0;
    end else if (|dac_shift[32:DAC_W]) begin
      dac_clamp = '1;
    end else begin
      dac_clamp = dac_shift[DAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= tick_load;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && tick_load) begin
      s1_meta_r <= meta;
    end
    if (s2_free && s1_v_r) begin
      s2_meta_r       <= s1_meta_r;
      s2_pwm_first_r  <= pwm_first_p[31:16];
      s2_pwm_second_r <= pwm_second_p[31:16];
      s2_dac_prod_r   <= dac_prod;
    end
    if (out_free && s2_v_r) begin
      out_r.underflow      <= s2_meta_r.underflow;
      out_r.playing_buffer <= s2_meta_r.playing_buffer;
      out_r.buffer_swapped <= s2_meta_r.buffer_swapped;
      if (s2_meta_r.underflow) begin
        out_r.pwm_first  <= '0;
        out_r.pwm_second <= '0;
        out_r.dac_code   <= '0;
      end else begin
        out_r.pwm_first  <= s2_pwm_first_r;
        out_r.pwm_second <= s2_pwm_second_r;
        out_r.dac_code   <= dac_clamp;
      end
    end
  end

  assign out_valid = out_v_r;
  assign result    = out_r;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for ping_pong_audio_pwm_dac_output: random and directed transfers
// with a scoreboard built on a local model of the two sample buffers and playback.
// Depends on ppdac_pkg and the block's RTL only.
module tb;
  import ppdac_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 8;
  localparam int PHASE_ITEMS = 300;
  localparam int GEN_VIEW = 0;
  localparam int DUT_VIEW = 1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic        bsel;
    logic [9:0]  sidx;
    logic [15:0] sval;
    logic [10:0] scnt;
  } play_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ping_pong_audio_pwm_dac_output #(.BUFFER_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // two copies of the playback state: one steers stimulus, one tracks accepted transfers
  logic [15:0] mirror_samples [2][2][DEPTH];
  bit          mirror_written [2][2][DEPTH];
  int          mirror_count   [2][2];
  int          mirror_playing [2];
  int          mirror_rd_idx  [2];
  cfg_t        cfg_shadow = '{dac_offset: 32'sd0, dac_gain: 17'sd1, dac_frac_bits: 5'd16,
                              pwm_period: 16'd1000, dac_takes_first: 1'b1};

  play_item_t stim_items [$];
  result_t    tick_results_due [$];
  play_item_t drv_item;
  int         items_made = 0;
  int         items_queued = 0;
  int         items_taken = 0;
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         phase_no = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  int         cycles = 0;

  function automatic logic [15:0] pwm_compare(input logic signed [15:0] s);
    longint biased;
    biased = longint'(s) + 32768;
    return 16'((biased * longint'(cfg_shadow.pwm_period)) >>> 16);
  endfunction

  function automatic bit play_step(input int cp, input play_item_t it, output result_t r);
    logic signed [15:0] s0, s1, pick;
    longint v;
    int pb, ix;
    r = '0;
    if (it.req == REQ_WRITE) begin
      mirror_samples[cp][it.bsel][it.sidx] = it.sval;
      mirror_written[cp][it.bsel][it.sidx] = 1'b1;
      return 1'b0;
    end
    if (it.req == REQ_COUNT) begin
      mirror_count[cp][it.bsel] = (it.scnt > DEPTH) ? DEPTH : int'(it.scnt);
      return 1'b0;
    end
    if (it.req != REQ_TICK) return 1'b0;
    pb = mirror_playing[cp];
    ix = mirror_rd_idx[cp];
    r.playing_buffer = pb[0];
    if (mirror_count[cp][pb] == 0) begin
      r.underflow = 1'b1;
      return 1'b1;
    end
    s0 = mirror_samples[cp][pb][ix];
    s1 = (ix + 1 < DEPTH) ? mirror_samples[cp][pb][ix + 1] : 16'sd0;
    r.pwm_first = pwm_compare(s0);
    r.pwm_second = pwm_compare(s1);
    pick = cfg_shadow.dac_takes_first ? s0 : s1;
    v = longint'($signed(cfg_shadow.dac_offset)) +
        longint'($signed(cfg_shadow.dac_gain)) * longint'(pick);
    v = v >>> cfg_shadow.dac_frac_bits;
    r.dac_code = (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : v[9:0];
    mirror_rd_idx[cp] = ix + 2;
    if (mirror_count[cp][pb] <= ix + 2) begin
      mirror_count[cp][pb] = 0;
      mirror_playing[cp] = pb ^ 1;
      mirror_rd_idx[cp] = 0;
      r.buffer_swapped = 1'b1;
    end
    r.playing_buffer = mirror_playing[cp][0];
    return 1'b1;
  endfunction

  function automatic play_item_t mk(input logic [1:0] req, input int b, input int idx,
                                    input int val, input int cnt);
    play_item_t it;
    it.req = req;
    it.bsel = b[0];
    it.sidx = idx[9:0];
    it.sval = val[15:0];
    it.scnt = cnt[10:0];
    return it;
  endfunction

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // a tick never reads an entry that was never written: fill those first
  task automatic queue_item(input play_item_t it);
    play_item_t fill;
    result_t r;
    int pb, e;
    pb = mirror_playing[GEN_VIEW];
    if (it.req == REQ_TICK && mirror_count[GEN_VIEW][pb] != 0) begin
      for (e = mirror_rd_idx[GEN_VIEW]; e <= mirror_rd_idx[GEN_VIEW] + 1 && e < DEPTH; e++) begin
        if (!mirror_written[GEN_VIEW][pb][e]) begin
          fill = mk(REQ_WRITE, pb, e, $urandom, $urandom);
          void'(play_step(GEN_VIEW, fill, r));
          stim_items.push_back(fill);
          items_queued++;
          items_made++;
        end
      end
    end
    void'(play_step(GEN_VIEW, it, r));
    stim_items.push_back(it);
    items_queued++;
    if (it.req != REQ_UNUSED) items_made++;
  endtask

  task automatic play_block();
    int t, n, k, i;
    t = (mirror_count[GEN_VIEW][mirror_playing[GEN_VIEW]] != 0) ?
        mirror_playing[GEN_VIEW] ^ 1 : $urandom_range(1);
    n = ($urandom_range(9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
    for (i = 0; i <= n && i < DEPTH; i++)
      queue_item(mk(REQ_WRITE, t, i, $urandom, $urandom));
    queue_item(mk(REQ_COUNT, t, $urandom, $urandom, n));
    k = $urandom_range(1, n / 2 + 2);
    for (i = 0; i < k; i++)
      queue_item(mk(REQ_TICK, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      play_block();
    else if (pick < 75)
      queue_item(mk(REQ_TICK, $urandom, $urandom, $urandom, $urandom));
    else if (pick < 87)
      queue_item(mk(REQ_WRITE, $urandom, $urandom, $urandom, $urandom));
    else if (pick < 92)
      queue_item(mk(REQ_COUNT, $urandom, $urandom, $urandom, $urandom_range(0, 20)));
    else if (pick < 95)
      queue_item(mk(REQ_COUNT, $urandom, $urandom, $urandom, $urandom_range(0, 2047)));
    else
      queue_item(mk(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic run_directed();
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    queue_item(mk(REQ_UNUSED, 1, 1023, 16'hFFFF, 2047));
    queue_item(mk(REQ_WRITE, 0, 0, 16'h8000, 0));
    queue_item(mk(REQ_WRITE, 0, 1, 16'h7FFF, 0));
    queue_item(mk(REQ_WRITE, 0, 2, 16'h0000, 0));
    queue_item(mk(REQ_WRITE, 0, 3, 16'hFFFF, 0));
    queue_item(mk(REQ_COUNT, 0, 0, 0, 3));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    queue_item(mk(REQ_TICK, 1, 0, 0, 0));
    queue_item(mk(REQ_WRITE, 1, 1023, 16'h7FFF, 0));
    queue_item(mk(REQ_WRITE, 1, 1022, 16'h8000, 0));
    queue_item(mk(REQ_COUNT, 1, 0, 0, 2047));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    // lower the count below the read index: finishes on the next tick
    queue_item(mk(REQ_COUNT, 1, 0, 0, 2));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
    queue_item(mk(REQ_COUNT, 0, 0, 0, 0));
    queue_item(mk(REQ_TICK, 0, 0, 0, 0));
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DAC_OFFSET:      cfg_shadow.dac_offset = val;
      REG_DAC_GAIN:        cfg_shadow.dac_gain = val[16:0];
      REG_DAC_FRAC_BITS:   cfg_shadow.dac_frac_bits = val[4:0];
      REG_PWM_PERIOD:      cfg_shadow.pwm_period = val[15:0];
      REG_DAC_TAKES_FIRST: cfg_shadow.dac_takes_first = val[0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [31:0] off, input int gain, input int frac,
                               input int period, input int first);
    cfg_write(REG_DAC_OFFSET, off);
    cfg_write(REG_DAC_GAIN, gain);
    cfg_write(REG_DAC_FRAC_BITS, frac);
    cfg_write(REG_PWM_PERIOD, period);
    cfg_write(REG_DAC_TAKES_FIRST, first);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    int ph, frac;
    for (int c = 0; c < 2; c++) begin
      for (int b = 0; b < 2; b++) begin
        mirror_count[c][b] = 0;
        for (int i = 0; i < DEPTH; i++) begin
          mirror_samples[c][b][i] = '0;
          mirror_written[c][b][i] = 1'b0;
        end
      end
      mirror_playing[c] = 0;
      mirror_rd_idx[c] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (ph = 0; ph < 4; ph++) begin
      phase_no = ph;
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_registers(32'h8000_0000, 65535, 31, 65535, 0);
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          set_registers(32'h7FFF_FFFF, -65536, 0, 1, 1);
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          frac = $urandom_range(4, 14);
          set_registers((512 << frac) + int'($urandom_range(0, (1 << frac) - 1)),
                        int'($urandom_range(0, (1 << frac) >> 4)) - ((1 << frac) >> 5),
                        frac, $urandom_range(1, 65535), $urandom_range(1));
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
      endcase
      items_made = 0;
      if (ph == 0) run_directed();
      while (items_made < PHASE_ITEMS) random_step();
      // hold until every expected result has arrived
      while (items_taken != items_queued || tick_results_due.size() != 0)
        @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end
    if (errors == 0) begin
      $display("ping_pong_audio_pwm_dac_output verification clean");
    end else begin
      $display("ping_pong_audio_pwm_dac_output verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    result_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        items_taken <= items_taken + 1;
        if (play_step(DUT_VIEW, drv_item, r)) tick_results_due.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = stim_items.pop_front();
          in_tdata <= {3'b000, drv_item.scnt, drv_item.sval, drv_item.sidx};
          in_tuser <= {drv_item.bsel, drv_item.req};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pwm_first = out_tdata[15:0];
        got.pwm_second = out_tdata[31:16];
        got.dac_code = out_tdata[41:32];
        got.playing_buffer = out_tdata[42];
        got.underflow = out_tuser[0];
        got.buffer_swapped = out_tuser[1];
        if (tick_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual %0h", $time, got);
        end else begin
          want = tick_results_due.pop_front();
          check_field("underflow", want.underflow, got.underflow);
          check_field("pwm_first", want.pwm_first, got.pwm_first);
          check_field("pwm_second", want.pwm_second, got.pwm_second);
          check_field("dac_code", want.dac_code, got.dac_code);
          check_field("playing_buffer", want.playing_buffer, got.playing_buffer);
          check_field("buffer_swapped", want.buffer_swapped, got.buffer_swapped);
        end
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && phase_no == 0 && items_taken >= 150) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ping_pong_audio_pwm_dac_output verification failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/ppdac_pkg.sv
rtl/ppdac_store.sv
rtl/ppdac_ctrl.sv
rtl/ppdac_math.sv
rtl/ping_pong_audio_pwm_dac_output.sv
verif/tb.sv
